@@ rtl/cnew_pkg.sv @@
// ----------------------------------------------------------------------------
// cnew_pkg: shared types, constants and helpers for the cpio newc walker
// Holds the header field layout, the entry record type and the small
// character decoders used by the parser.
// ----------------------------------------------------------------------------
package cnew_pkg;

    // Header layout of a newc entry.
    localparam int unsigned HEADER_BYTES = 110;
    localparam int unsigned MODE_AT      = 14;
    localparam int unsigned SIZE_AT      = 54;
    localparam int unsigned NAMELEN_AT   = 94;
    localparam int unsigned HEX_DIGITS   = 8;
    localparam int unsigned END_NAME_LEN = 10;

    // File type bits of the mode field.
    localparam logic [31:0] C_FMASK = 32'o170000;
    localparam logic [31:0] C_REG   = 32'o100000;
    localparam logic [31:0] C_DIR   = 32'o040000;

    // Kind codes of the entry record.
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_DIR   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    // Error flag positions.
    localparam int unsigned FLAG_MODE    = 0;
    localparam int unsigned FLAG_SIZE    = 1;
    localparam int unsigned FLAG_NAMELEN = 2;

    // One decoded entry, as handed from the parser to the output stage.
    typedef struct packed {
        logic [31:0] entry_offset;
        logic [31:0] content_offset;
        logic [31:0] file_size;
        logic [31:0] name_size;
        logic [31:0] file_mode;
        logic [1:0]  file_kind;
        logic        is_trailer;
        logic        dot_name;
        logic        bad_hex;
    } entry_rec_t;

    // Decode an ASCII hex character: bit 4 set means the character is not hex.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                r = {1'b0, 4'(c - 8'h30)};
            end
            else if (c inside {[8'h61:8'h66]}) begin
                r = {1'b0, 4'(c - 8'h57)};
            end
            else if (c inside {[8'h41:8'h46]}) begin
                r = {1'b0, 4'(c - 8'h37)};
            end
            else begin
                r = 5'b10000;
            end
            return r;
        end
    endfunction

    // Characters of the trailer name TRAILER!!!.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                4'd0:    r = 8'h54;
                4'd1:    r = 8'h52;
                4'd2:    r = 8'h41;
                4'd3:    r = 8'h49;
                4'd4:    r = 8'h4C;
                4'd5:    r = 8'h45;
                4'd6:    r = 8'h52;
                default: r = 8'h21;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/cnew_if.sv @@
// ----------------------------------------------------------------------------
// cnew_if: stream channels of the cpio newc walker
// A byte channel for the archive and a record channel for decoded entries,
// both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cnew_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface cnew_entry_if;
    logic        valid;
    logic        ready;
    logic [31:0] entry_offset;
    logic [31:0] content_offset;
    logic [31:0] file_size;
    logic [31:0] name_size;
    logic [31:0] file_mode;
    logic [1:0]  file_kind;
    logic        is_trailer;
    logic        dot_name;
    logic        bad_hex;

    modport source (
        output valid, output entry_offset, output content_offset, output file_size,
        output name_size, output file_mode, output file_kind, output is_trailer,
        output dot_name, output bad_hex, input ready
    );
    modport sink (
        input valid, input entry_offset, input content_offset, input file_size,
        input name_size, input file_mode, input file_kind, input is_trailer,
        input dot_name, input bad_hex, output ready
    );
endinterface

@@ rtl/cnew_parser.sv @@
// ----------------------------------------------------------------------------
// cnew_parser: per-byte parse state of the cpio newc walker
// Tracks the phase of the current entry, decodes the hex header fields and
// builds an entry record on the byte that ends the name.
// ----------------------------------------------------------------------------
module cnew_parser #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                restart,
    output logic                rec_valid,
    output cnew_pkg::entry_rec_t rec
);
    import cnew_pkg::*;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_NAME     = 3'd1;
    localparam logic [2:0] PH_NAME_PAD = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_DATA_PAD = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;

    localparam int unsigned PW = POSITION_WIDTH;

    logic [2:0]    phase_reg, phase_next;
    logic [31:0]   count_reg, count_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] start_reg, start_next;
    logic [31:0]   mode_reg, mode_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   nlen_reg, nlen_next;
    logic [2:0]    flags_reg, flags_next;
    logic          tmatch_reg, tmatch_next;
    logic          dot_reg, dot_next;

    logic [2:0]    cur_phase;
    logic [31:0]   cur_count;
    logic [PW-1:0] cur_pos;
    logic          cur_tmatch;
    logic          cur_dot;
    logic          hdr_first;
    logic [31:0]   cnt_inc;
    logic [4:0]    hx;
    logic [31:0]   eff_mode, eff_size, eff_nlen;
    logic [1:0]    name_pad, data_pad;
    logic [31:0]   plen;
    logic          finish;
    logic          trailer;
    logic [PW-1:0] content;
    logic [31:0]   masked_mode;

    // Step past phases of zero length; the header is never empty.
    function automatic logic [2:0] skip_empty(input logic [2:0] p, input logic [1:0] npad,
                                              input logic [31:0] fsize,
                                              input logic [1:0] dpad);
        logic [2:0] q;
        begin
            q = p;
            if (q == PH_NAME_PAD && npad == 2'd0) begin
                q = PH_DATA;
            end
            if (q == PH_DATA && fsize == 32'd0) begin
                q = PH_DATA_PAD;
            end
            if (q == PH_DATA_PAD && dpad == 2'd0) begin
                q = PH_HEADER;
            end
            return q;
        end
    endfunction

    // A restart byte sees the reset state.
    assign cur_phase  = restart ? PH_HEADER : phase_reg;
    assign cur_count  = restart ? 32'd0 : count_reg;
    assign cur_pos    = restart ? '0 : pos_reg;
    assign cur_tmatch = restart ? 1'b1 : tmatch_reg;
    assign cur_dot    = restart ? 1'b0 : dot_reg;
    assign hdr_first  = (cur_phase == PH_HEADER) && (cur_count == 32'd0);
    assign cnt_inc    = cur_count + 32'd1;
    assign hx         = hex_value(data_byte);
    assign pos_next   = cur_pos + PW'(1);

    // Header field accumulation; the first header byte clears the fields.
    always_comb
    begin
        start_next = restart ? '0 : start_reg;
        mode_next  = restart ? 32'd0 : mode_reg;
        size_next  = restart ? 32'd0 : size_reg;
        nlen_next  = restart ? 32'd0 : nlen_reg;
        flags_next = restart ? 3'd0 : flags_reg;
        if (hdr_first) begin
            start_next = cur_pos;
            mode_next  = 32'd0;
            size_next  = 32'd0;
            nlen_next  = 32'd0;
            flags_next = 3'd0;
        end
        if (cur_phase == PH_HEADER) begin
            if (cur_count inside {[MODE_AT:MODE_AT + HEX_DIGITS - 1]}) begin
                mode_next = {mode_next[27:0], hx[3:0]};
                if (hx[4]) begin
                    flags_next[FLAG_MODE] = 1'b1;
                end
            end
            else if (cur_count inside {[SIZE_AT:SIZE_AT + HEX_DIGITS - 1]}) begin
                size_next = {size_next[27:0], hx[3:0]};
                if (hx[4]) begin
                    flags_next[FLAG_SIZE] = 1'b1;
                end
            end
            else if (cur_count inside {[NAMELEN_AT:NAMELEN_AT + HEX_DIGITS - 1]}) begin
                nlen_next = {nlen_next[27:0], hx[3:0]};
                if (hx[4]) begin
                    flags_next[FLAG_NAMELEN] = 1'b1;
                end
            end
        end
    end

    // Field values after the bad-digit rule, and the padding they imply.
    assign eff_mode = flags_next[FLAG_MODE] ? 32'd0 : mode_next;
    assign eff_size = flags_next[FLAG_SIZE] ? 32'd0 : size_next;
    assign eff_nlen = flags_next[FLAG_NAMELEN] ? 32'd0 : nlen_next;
    assign name_pad = 2'd0 - (eff_nlen[1:0] + 2'(HEADER_BYTES));
    assign data_pad = 2'd0 - eff_size[1:0];

    // Length of the current skip phase.
    always_comb
    begin
        case (cur_phase)
            PH_NAME_PAD: plen = {30'd0, name_pad};
            PH_DATA:     plen = eff_size;
            PH_DATA_PAD: plen = {30'd0, data_pad};
            default:     plen = eff_nlen;
        endcase
    end

    // Phase sequencing and name checks.
    always_comb
    begin
        phase_next  = cur_phase;
        count_next  = cur_count;
        tmatch_next = cur_tmatch;
        dot_next    = cur_dot;
        finish      = 1'b0;
        case (cur_phase)
            PH_HEADER:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= 32'(HEADER_BYTES)) begin
                    tmatch_next = 1'b1;
                    dot_next    = 1'b0;
                    count_next  = 32'd0;
                    if (eff_nlen == 32'd0) begin
                        tmatch_next = 1'b0;
                        finish      = 1'b1;
                    end
                    else begin
                        phase_next = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                if (cur_count < 32'(END_NAME_LEN) &&
                    data_byte != trailer_char(cur_count[3:0])) begin
                    tmatch_next = 1'b0;
                end
                if (cur_count == 32'd0) begin
                    dot_next = (data_byte == 8'h2E);
                end
                count_next = cnt_inc;
                if (cnt_inc >= eff_nlen) begin
                    finish = 1'b1;
                end
            end
            PH_NAME_PAD, PH_DATA, PH_DATA_PAD:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= plen) begin
                    count_next = 32'd0;
                    if (cur_phase == PH_DATA_PAD) begin
                        phase_next = PH_HEADER;
                    end
                    else begin
                        phase_next = skip_empty(cur_phase + 3'd1, name_pad, eff_size,
                                                data_pad);
                    end
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
        if (finish) begin
            count_next = 32'd0;
            if (trailer) begin
                phase_next = PH_DONE;
            end
            else begin
                phase_next = skip_empty(PH_NAME_PAD, name_pad, eff_size, data_pad);
            end
        end
    end

    // Entry record built on the byte that ends the name.
    assign trailer     = tmatch_next && (eff_nlen >= 32'(END_NAME_LEN));
    assign content     = start_next + PW'(HEADER_BYTES) + PW'(eff_nlen) + PW'(name_pad);
    assign masked_mode = eff_mode & C_FMASK;

    always_comb
    begin
        rec_valid          = finish;
        rec.entry_offset   = 32'(start_next);
        rec.content_offset = 32'(content);
        rec.file_size      = eff_size;
        rec.name_size      = eff_nlen;
        rec.file_mode      = eff_mode;
        if (masked_mode == C_REG) begin
            rec.file_kind = KIND_REG;
        end
        else if (masked_mode == C_DIR) begin
            rec.file_kind = KIND_DIR;
        end
        else begin
            rec.file_kind = KIND_OTHER;
        end
        rec.is_trailer = trailer;
        rec.dot_name   = (eff_nlen != 32'd0) && dot_next;
        rec.bad_hex    = |flags_next;
    end

    // Parse state registers, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 32'd0;
            pos_reg    <= '0;
            start_reg  <= '0;
            mode_reg   <= 32'd0;
            size_reg   <= 32'd0;
            nlen_reg   <= 32'd0;
            flags_reg  <= 3'd0;
            tmatch_reg <= 1'b1;
            dot_reg    <= 1'b0;
        end
        else if (take) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            mode_reg   <= mode_next;
            size_reg   <= size_next;
            nlen_reg   <= nlen_next;
            flags_reg  <= flags_next;
            tmatch_reg <= tmatch_next;
            dot_reg    <= dot_next;
        end
    end

endmodule

@@ rtl/cnew_out_stage.sv @@
// ----------------------------------------------------------------------------
// cnew_out_stage: result register of the cpio newc walker
// Holds one entry record until the downstream side takes it and tells the
// input side when a new record may be loaded.
// ----------------------------------------------------------------------------
module cnew_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cnew_pkg::entry_rec_t rec,
    output logic                 can_load,
    cnew_entry_if.source         entry
);
    import cnew_pkg::*;

    logic       valid_reg, valid_next;
    entry_rec_t rec_reg;

    // Room when empty or when the held word leaves this cycle.
    assign can_load = !valid_reg || entry.ready;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (entry.ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // The record itself needs no reset.
    always_ff @(posedge clk)
    begin
        if (load) begin
            rec_reg <= rec;
        end
    end

    assign entry.valid          = valid_reg;
    assign entry.entry_offset   = rec_reg.entry_offset;
    assign entry.content_offset = rec_reg.content_offset;
    assign entry.file_size      = rec_reg.file_size;
    assign entry.name_size      = rec_reg.name_size;
    assign entry.file_mode      = rec_reg.file_mode;
    assign entry.file_kind      = rec_reg.file_kind;
    assign entry.is_trailer     = rec_reg.is_trailer;
    assign entry.dot_name       = rec_reg.dot_name;
    assign entry.bad_hex        = rec_reg.bad_hex;

endmodule

@@ rtl/cpio_newc_entry_walker.sv @@
// A record appears on the entry channel in the cycle after the byte that ends its name is accepted.
// One archive byte is taken per cycle; the parse state is updated on each accepted byte.
// The input stalls only while a finished record waits and the entry side is not ready.
// Reset (rst_n low, asynchronous) returns the parser to the start of a header at position 0
// and empties the result register; a byte marked restart is parsed as if the parser were reset.
// ----------------------------------------------------------------------------
// cpio_newc_entry_walker: cpio newc archive entry walker
// Streams an archive byte by byte and emits one decoded record per entry.
// ----------------------------------------------------------------------------
module cpio_newc_entry_walker #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    cnew_byte_if.sink     archive,
    cnew_entry_if.source  entry
);
    import cnew_pkg::*;

    logic       take;
    logic       rec_valid;
    logic       can_load;
    entry_rec_t rec;

    // A byte is taken whenever one is offered and the result register has room.
    assign archive.ready = can_load;
    assign take          = archive.valid && can_load;

    cnew_parser #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (archive.data_byte),
        .restart   (archive.restart),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    cnew_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && rec_valid),
        .rec      (rec),
        .can_load (can_load),
        .entry    (entry)
    );

endmodule

@@ verif/cpio_newc_entry_walker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpio_newc_entry_walker_tb: self-checking bench for the cpio newc entry walker
// Streams whole newc entries, broken entries and loose noise into the walker.
// It predicts each entry record from its own parse of the stream, or takes a
// record typed in for a directed entry, and checks each record field by field
// as it leaves the block, with random idling on both channels.
// ----------------------------------------------------------------------------
module cpio_newc_entry_walker_tb;
    import cnew_pkg::*;

    // Parse phases of the walker model.
    typedef enum logic [2:0] {
        WK_HEADER,
        WK_NAME,
        WK_NAME_PAD,
        WK_DATA,
        WK_DATA_PAD,
        WK_DONE
    } walk_phase_e;

    // How the name bytes of a generated entry are formed.
    typedef enum logic [1:0] {
        NM_PLAIN,
        NM_DOT,
        NM_TRAILER,
        NM_NEAR
    } name_kind_e;

    // One archive entry to be streamed.
    typedef struct {
        bit          rs;
        bit          up;
        bit          raw;
        logic [31:0] mode;
        logic [31:0] fsize;
        logic [31:0] nsize;
        logic [2:0]  bad;
        name_kind_e  nk;
        int          cut;
        int          junk;
        bit          typed;
        entry_rec_t  rec;
    } entry_row_t;

    localparam logic [79:0] TRAILER_NAME = "TRAILER!!!";
    localparam logic [47:0] NEWC_MAGIC   = "070701";
    localparam logic [7:0]  DOT_CHAR     = 8'h2E;
    localparam logic [7:0]  ODD_CHAR     = 8'h3F;
    localparam int          HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    logic drv_typed;
    logic calm;
    logic hold_go;
    bit   hold_done;

    cnew_byte_if  arch_ch ();
    cnew_entry_if ent_ch ();

    cpio_newc_entry_walker #(.POSITION_WIDTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .archive (arch_ch),
        .entry (ent_ch)
    );

    // Walker model state.
    walk_phase_e wk_phase;
    logic [31:0] wk_count;
    logic [31:0] wk_pos;
    logic [31:0] wk_start;
    logic [31:0] wk_mode;
    logic [31:0] wk_size;
    logic [31:0] wk_nlen;
    logic [2:0]  wk_bad;
    logic        wk_trl;
    logic        wk_dot;

    entry_rec_t entry_q[$];
    entry_rec_t typed_q[$];
    entry_row_t dir_rows[$];

    int errs;
    int bytes_sent;
    int entries_sent;
    int recs_checked;
    int trailers_seen;
    int dots_seen;
    int bad_seen;
    int restarts_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the walker
    // ------------------------------------------------------------------

    // Value of an ASCII hex character; bit 4 set marks a non-hex character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                r = {1'b0, c[3:0]};
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                r = {1'b0, c[3:0] + 4'd9};
            else
                r = 5'h10;
            return r;
        end
    endfunction

    function automatic logic [7:0] trailer_byte(input int i);
        return TRAILER_NAME[79 - 8 * i -: 8];
    endfunction

    // A field with a bad digit reads as zero.
    function automatic logic [31:0] mode_seen();
        return wk_bad[FLAG_MODE] ? 32'd0 : wk_mode;
    endfunction

    function automatic logic [31:0] size_seen();
        return wk_bad[FLAG_SIZE] ? 32'd0 : wk_size;
    endfunction

    function automatic logic [31:0] nlen_seen();
        return wk_bad[FLAG_NAMELEN] ? 32'd0 : wk_nlen;
    endfunction

    function automatic logic [31:0] name_gap();
        return (32'd4 - ((32'(HEADER_BYTES) + nlen_seen()) & 32'd3)) & 32'd3;
    endfunction

    function automatic logic [31:0] seg_len(input walk_phase_e p);
        logic [31:0] r;
        begin
            case (p)
                WK_NAME:     r = nlen_seen();
                WK_NAME_PAD: r = name_gap();
                WK_DATA:     r = size_seen();
                WK_DATA_PAD: r = (32'd4 - (size_seen() & 32'd3)) & 32'd3;
                default:     r = 32'(HEADER_BYTES);
            endcase
            return r;
        end
    endfunction

    function automatic walk_phase_e next_phase(input walk_phase_e p);
        return (p == WK_DATA_PAD) ? WK_HEADER : walk_phase_e'(p + 3'd1);
    endfunction

    task automatic wipe_walker();
        begin
            wk_phase = WK_HEADER;
            wk_count = '0;
            wk_pos   = '0;
            wk_start = '0;
            wk_mode  = '0;
            wk_size  = '0;
            wk_nlen  = '0;
            wk_bad   = '0;
            wk_trl   = 1'b1;
            wk_dot   = 1'b0;
        end
    endtask

    // Enter a phase, passing over any phase of zero length.
    task automatic advance_to(input walk_phase_e p);
        walk_phase_e q;
        begin
            q = p;
            while (q != WK_HEADER && seg_len(q) == 0)
                q = next_phase(q);
            wk_phase = q;
            wk_count = '0;
        end
    endtask

    // The name has ended: queue the entry record.
    task automatic close_name(input logic typed);
        entry_rec_t  r;
        logic [31:0] n;
        logic [31:0] m;
        begin
            n = nlen_seen();
            m = mode_seen();
            r.entry_offset   = wk_start;
            r.content_offset = wk_start + 32'(HEADER_BYTES) + n + name_gap();
            r.file_size      = size_seen();
            r.name_size      = n;
            r.file_mode      = m;
            if ((m & C_FMASK) == C_REG)
                r.file_kind = KIND_REG;
            else if ((m & C_FMASK) == C_DIR)
                r.file_kind = KIND_DIR;
            else
                r.file_kind = KIND_OTHER;
            r.is_trailer = wk_trl && (n >= END_NAME_LEN);
            r.dot_name   = (n != 0) && wk_dot;
            r.bad_hex    = |wk_bad;
            if (r.is_trailer)
            begin
                wk_phase = WK_DONE;
                wk_count = '0;
            end
            else
            begin
                advance_to(WK_NAME_PAD);
            end
            if (typed && typed_q.size() != 0)
                entry_q.push_back(typed_q.pop_front());
            else
                entry_q.push_back(r);
        end
    endtask

    // Advance the model by one accepted archive word.
    task automatic walk_byte(input logic [7:0] c, input logic rs, input logic typed);
        logic [4:0] nb;
        begin
            if (rs)
            begin
                wipe_walker();
                restarts_seen++;
            end
            nb = nibble_of(c);
            case (wk_phase)
                WK_HEADER:
                begin
                    if (wk_count == 0)
                    begin
                        wk_start = wk_pos;
                        wk_mode  = '0;
                        wk_size  = '0;
                        wk_nlen  = '0;
                        wk_bad   = '0;
                    end
                    if (wk_count >= MODE_AT && wk_count < MODE_AT + HEX_DIGITS)
                    begin
                        wk_mode = {wk_mode[27:0], nb[3:0]};
                        if (nb[4])
                            wk_bad[FLAG_MODE] = 1'b1;
                    end
                    else if (wk_count >= SIZE_AT && wk_count < SIZE_AT + HEX_DIGITS)
                    begin
                        wk_size = {wk_size[27:0], nb[3:0]};
                        if (nb[4])
                            wk_bad[FLAG_SIZE] = 1'b1;
                    end
                    else if (wk_count >= NAMELEN_AT && wk_count < NAMELEN_AT + HEX_DIGITS)
                    begin
                        wk_nlen = {wk_nlen[27:0], nb[3:0]};
                        if (nb[4])
                            wk_bad[FLAG_NAMELEN] = 1'b1;
                    end
                    wk_count++;
                    if (wk_count >= HEADER_BYTES)
                    begin
                        wk_trl   = 1'b1;
                        wk_dot   = 1'b0;
                        wk_count = '0;
                        // An empty name ends on the last header byte.
                        if (nlen_seen() == 0)
                        begin
                            wk_trl = 1'b0;
                            close_name(typed);
                        end
                        else
                        begin
                            wk_phase = WK_NAME;
                        end
                    end
                end
                WK_NAME:
                begin
                    if (wk_count < END_NAME_LEN && c != trailer_byte(int'(wk_count)))
                        wk_trl = 1'b0;
                    if (wk_count == 0)
                        wk_dot = (c == DOT_CHAR);
                    wk_count++;
                    if (wk_count >= nlen_seen())
                        close_name(typed);
                end
                WK_NAME_PAD, WK_DATA, WK_DATA_PAD:
                begin
                    wk_count++;
                    if (wk_count >= seg_len(wk_phase))
                        advance_to(next_phase(wk_phase));
                end
                default:
                begin
                end
            endcase
            wk_pos = wk_pos + 32'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t: %s expected %h, actual %h", $time, nm, want, got);
                errs++;
            end
        end
    endtask

    task automatic check_rec(input entry_rec_t want, input entry_rec_t got);
        begin
            check_field("entry_offset", want.entry_offset, got.entry_offset);
            check_field("content_offset", want.content_offset, got.content_offset);
            check_field("file_size", want.file_size, got.file_size);
            check_field("name_size", want.name_size, got.name_size);
            check_field("file_mode", want.file_mode, got.file_mode);
            check_field("file_kind", 32'(want.file_kind), 32'(got.file_kind));
            check_field("is_trailer", 32'(want.is_trailer), 32'(got.is_trailer));
            check_field("dot_name", 32'(want.dot_name), 32'(got.dot_name));
            check_field("bad_hex", 32'(want.bad_hex), 32'(got.bad_hex));
        end
    endtask

    // Records leaving the block are checked first, then the accepted word
    // advances the model, so the order of the two steps is fixed.
    always @(posedge clk)
    begin : watch
        entry_rec_t got;
        entry_rec_t want;
        if (rst_n)
        begin
            if (ent_ch.valid && ent_ch.ready)
            begin
                got.entry_offset   = ent_ch.entry_offset;
                got.content_offset = ent_ch.content_offset;
                got.file_size      = ent_ch.file_size;
                got.name_size      = ent_ch.name_size;
                got.file_mode      = ent_ch.file_mode;
                got.file_kind      = ent_ch.file_kind;
                got.is_trailer     = ent_ch.is_trailer;
                got.dot_name       = ent_ch.dot_name;
                got.bad_hex        = ent_ch.bad_hex;
                if (entry_q.size() == 0)
                begin
                    $display("%0t: record expected none, actual offset %h", $time,
                             got.entry_offset);
                    errs++;
                end
                else
                begin
                    want = entry_q.pop_front();
                    check_rec(want, got);
                    recs_checked++;
                    if (want.is_trailer)
                        trailers_seen++;
                    if (want.dot_name)
                        dots_seen++;
                    if (want.bad_hex)
                        bad_seen++;
                end
            end
            if (arch_ch.valid && arch_ch.ready)
                walk_byte(arch_ch.data_byte, arch_ch.restart, drv_typed);
        end
    end

    // ------------------------------------------------------------------
    // Entry side: random stalls, and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int k;
        ent_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                ent_ch.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            ent_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit up);
        begin
            // Digits from '0', letters from 'A' or 'a'.
            if (v < 4'd10)
                return 8'h30 + {4'h0, v};
            else
                return (up ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
        end
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        logic [4:0] nb;
        begin
            c  = 8'($urandom_range(0, 255));
            nb = nibble_of(c);
            while (!nb[4])
            begin
                c  = 8'($urandom_range(0, 255));
                nb = nibble_of(c);
            end
            return c;
        end
    endfunction

    function automatic entry_rec_t mk_rec(input logic [31:0] eo, input logic [31:0] co,
                                          input logic [31:0] fs, input logic [31:0] ns,
                                          input logic [31:0] md, input logic [1:0] kd,
                                          input logic tr, input logic dt, input logic bh);
        entry_rec_t r;
        begin
            r.entry_offset   = eo;
            r.content_offset = co;
            r.file_size      = fs;
            r.name_size      = ns;
            r.file_mode      = md;
            r.file_kind      = kd;
            r.is_trailer     = tr;
            r.dot_name       = dt;
            r.bad_hex        = bh;
            return r;
        end
    endfunction

    task automatic add_row(input bit rs, input bit up, input logic [31:0] mode,
                           input logic [31:0] fsize, input logic [31:0] nsize,
                           input logic [2:0] bad, input name_kind_e nk, input int cut,
                           input int junk, input bit typed, input entry_rec_t rec);
        entry_row_t r;
        begin
            r.rs    = rs;
            r.up    = up;
            r.raw   = 1'b0;
            r.mode  = mode;
            r.fsize = fsize;
            r.nsize = nsize;
            r.bad   = bad;
            r.nk    = nk;
            r.cut   = cut;
            r.junk  = junk;
            r.typed = typed;
            r.rec   = rec;
            dir_rows.push_back(r);
        end
    endtask

    // Offer one archive word, idling at random beforehand.
    task automatic put_byte(input logic [7:0] b, input logic rs, input logic typed);
        begin
            while (!calm && $urandom_range(0, 99) < 24)
            begin
                arch_ch.valid <= 1'b0;
                @(posedge clk);
            end
            arch_ch.valid     <= 1'b1;
            arch_ch.data_byte <= b;
            arch_ch.restart   <= rs;
            drv_typed         <= typed;
            do
                @(posedge clk);
            while (!arch_ch.ready);
            bytes_sent++;
        end
    endtask

    // Build the words of one entry (header, name, padding, data) and stream them.
    task automatic send_entry(input entry_row_t r);
        logic [7:0]  bq[$];
        logic [7:0]  ch;
        logic [31:0] n;
        logic [31:0] fs;
        logic [31:0] v;
        int          bpos[3];
        int          i;
        int          f;
        int          d;
        int          lim;
        begin
            n   = r.bad[FLAG_NAMELEN] ? 32'd0 : r.nsize;
            fs  = r.bad[FLAG_SIZE] ? 32'd0 : r.fsize;
            lim = (r.cut > 0) ? r.cut : 32'h7fffffff;
            for (i = 0; i < 3; i++)
                bpos[i] = $urandom_range(0, 7);
            if (r.typed)
                typed_q.push_back(r.rec);

            // Header: magic, then thirteen eight-digit hex fields.
            for (i = 0; i < HEADER_BYTES; i++)
            begin
                if (r.raw)
                    ch = 8'($urandom_range(0, 255));
                else if (i < 6)
                    ch = NEWC_MAGIC[47 - 8 * i -: 8];
                else
                    ch = hex_char(4'($urandom_range(0, 15)), r.up);
                if (i >= 6)
                begin
                    f = (i - 6) / 8;
                    d = (i - 6) % 8;
                    if (f == 1 || f == 6 || f == 11)
                    begin
                        v  = (f == 1) ? r.mode : ((f == 6) ? r.fsize : r.nsize);
                        ch = hex_char(v[31 - 4 * d -: 4], r.up);
                        if (f == 1 && r.bad[FLAG_MODE] && d == bpos[0])
                            ch = rand_nonhex();
                        if (f == 6 && r.bad[FLAG_SIZE] && d == bpos[1])
                            ch = rand_nonhex();
                        if (f == 11 && r.bad[FLAG_NAMELEN] && d == bpos[2])
                            ch = rand_nonhex();
                    end
                end
                bq.push_back(ch);
            end

            // Name, ending in a terminator unless a pattern fills the last byte.
            for (i = 0; i < n && bq.size() < lim; i++)
            begin
                ch = 8'($urandom_range(0, 255));
                if (i == n - 1)
                    ch = 8'h00;
                case (r.nk)
                    NM_DOT:
                        if (i == 0)
                            ch = DOT_CHAR;
                    NM_TRAILER:
                        if (i < END_NAME_LEN)
                            ch = trailer_byte(i);
                    NM_NEAR:
                        if (i < END_NAME_LEN - 1)
                            ch = trailer_byte(i);
                        else if (i == END_NAME_LEN - 1)
                            ch = ODD_CHAR;
                    default:
                        if (i == 0 && ch == DOT_CHAR)
                            ch = 8'h78;
                endcase
                bq.push_back(ch);
            end

            // Padding and data carry random content, which the block ignores.
            for (i = 0; i < ((4 - ((HEADER_BYTES + n) % 4)) % 4) && bq.size() < lim; i++)
                bq.push_back(8'($urandom_range(0, 255)));
            for (i = 0; i < fs && bq.size() < lim; i++)
                bq.push_back(8'($urandom_range(0, 255)));
            for (i = 0; i < ((4 - (fs % 4)) % 4) && bq.size() < lim; i++)
                bq.push_back(8'($urandom_range(0, 255)));
            for (i = 0; i < r.junk; i++)
                bq.push_back(8'($urandom_range(0, 255)));

            for (i = 0; i < bq.size() && i < lim + r.junk; i++)
                put_byte(bq[i], r.rs && (i == 0), r.typed);
            entries_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stim
        entry_row_t rr;
        int         ents;
        int         rand_bytes;
        int         sel;
        int         k;
        int         len;
        logic [31:0] n_eff;
        bit         need_restart;

        rst_n             <= 1'b0;
        arch_ch.valid     <= 1'b0;
        arch_ch.data_byte <= 8'h00;
        arch_ch.restart   <= 1'b0;
        drv_typed         <= 1'b0;
        calm              <= 1'b0;
        hold_go           <= 1'b0;
        errs          = 0;
        bytes_sent    = 0;
        entries_sent  = 0;
        recs_checked  = 0;
        trailers_seen = 0;
        dots_seen     = 0;
        bad_seen      = 0;
        restarts_seen = 0;
        wipe_walker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed entries; the record is typed in where it is plain to read.
        add_row(1, 1, 32'h000081A4, 32'd0, 32'd0, 3'b000, NM_PLAIN, 0, 0, 1,
                mk_rec(32'd0, 32'd112, 32'd0, 32'd0, 32'h81A4, KIND_REG, 0, 0, 0));
        add_row(1, 0, 32'h000041ED, 32'd5, 32'd2, 3'b000, NM_DOT, 0, 0, 1,
                mk_rec(32'd0, 32'd112, 32'd5, 32'd2, 32'h41ED, KIND_DIR, 0, 1, 0));
        add_row(0, 1, 32'h0000A1FF, 32'd1, 32'd6, 3'b000, NM_PLAIN, 0, 0, 0, '0);
        add_row(0, 0, 32'h00000000, 32'd2, 32'd7, 3'b000, NM_PLAIN, 0, 0, 0, '0);
        add_row(0, 1, 32'hFFFFFFFF, 32'd3, 32'd8, 3'b000, NM_DOT, 0, 0, 0, '0);
        // A nine-byte name that spells most of the trailer is not a trailer.
        add_row(0, 0, 32'h000081ED, 32'd4, 32'd9, 3'b000, NM_TRAILER, 0, 0, 0, '0);
        add_row(0, 1, 32'h000081A4, 32'd0, 32'd1, 3'b000, NM_PLAIN, 0, 0, 0, '0);
        add_row(0, 0, 32'h0000abcd, 32'd6, 32'd11, 3'b000, NM_NEAR, 0, 0, 0, '0);
        // Bad digits in each field in turn.
        add_row(1, 1, 32'h000081A4, 32'd0, 32'd0, 3'b001, NM_PLAIN, 0, 0, 1,
                mk_rec(32'd0, 32'd112, 32'd0, 32'd0, 32'd0, KIND_OTHER, 0, 0, 1));
        add_row(1, 1, 32'h000081B6, 32'd7, 32'd3, 3'b010, NM_PLAIN, 0, 0, 1,
                mk_rec(32'd0, 32'd116, 32'd0, 32'd3, 32'h81B6, KIND_REG, 0, 0, 1));
        add_row(1, 0, 32'h000081A4, 32'd4, 32'd5, 3'b100, NM_DOT, 0, 0, 1,
                mk_rec(32'd0, 32'd112, 32'd4, 32'd0, 32'h81A4, KIND_REG, 0, 0, 1));
        add_row(0, 1, 32'h000041ED, 32'd9, 32'd12, 3'b111, NM_PLAIN, 0, 0, 0, '0);
        add_row(0, 0, 32'h000081A4, 32'd1024, 32'd14, 3'b000, NM_PLAIN, 0, 0, 0, '0);
        // Largest sizes, each cut short by the restart of the next entry.
        add_row(0, 1, 32'h000081A4, 32'd0, 32'hFFFFFFFF, 3'b000, NM_PLAIN, 150, 0, 0, '0);
        add_row(1, 1, 32'h000081A4, 32'hFFFFFFFF, 32'd4, 3'b000, NM_PLAIN, 200, 0, 1,
                mk_rec(32'd0, 32'd116, 32'hFFFFFFFF, 32'd4, 32'h81A4, KIND_REG, 0, 0, 0));
        // Trailer; the words after it are ignored.
        add_row(1, 0, 32'h00000000, 32'd0, 32'd11, 3'b000, NM_TRAILER, 0, 20, 1,
                mk_rec(32'd0, 32'd124, 32'd0, 32'd11, 32'd0, KIND_OTHER, 1, 0, 0));
        add_row(1, 1, 32'h000081A4, 32'd3, 32'd6, 3'b000, NM_PLAIN, 0, 0, 0, '0);
        add_row(0, 1, 32'h00000000, 32'd3, 32'd10, 3'b000, NM_TRAILER, 0, 8, 0, '0);
        add_row(1, 0, 32'h00000000, 32'd12, 32'd13, 3'b000, NM_DOT, 0, 0, 0, '0);
        add_row(0, 1, 32'h00000000, 32'd0, 32'd10, 3'b001, NM_TRAILER, 0, 5, 0, '0);
        add_row(1, 1, 32'h000081A4, 32'd0, 32'd2, 3'b000, NM_PLAIN, 0, 0, 0, '0);

        foreach (dir_rows[i])
            send_entry(dir_rows[i]);

        // Let every outstanding record drain before the random part.
        arch_ch.valid <= 1'b0;
        @(posedge clk);
        while (entry_q.size() != 0)
            @(posedge clk);

        // Random entries, mostly well formed, with noise and broken entries.
        ents         = 0;
        rand_bytes   = bytes_sent;
        need_restart = 1'b1;
        while (bytes_sent - rand_bytes < 1850 || ents < 48)
        begin
            calm <= (ents >= 15 && ents < 25);
            if (ents == 5)
                hold_go <= 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                // Loose noise words; a restart must follow.
                len = $urandom_range(10, 150);
                for (k = 0; k < len; k++)
                    put_byte(8'($urandom_range(0, 255)), (k == 0) && $urandom_range(0, 1),
                             1'b0);
                need_restart = 1'b1;
            end
            else
            begin
                rr.rs    = need_restart || ($urandom_range(0, 99) < 4);
                rr.up    = $urandom_range(0, 1);
                rr.raw   = ($urandom_range(0, 99) < 20);
                rr.typed = 1'b0;
                rr.rec   = '0;
                rr.junk  = 0;
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    rr.mode = C_REG | 32'($urandom_range(0, 32'o7777));
                else if (sel < 65)
                    rr.mode = C_DIR | 32'($urandom_range(0, 32'o7777));
                else if (sel < 80)
                    rr.mode = 32'o120777;
                else
                    rr.mode = $urandom;
                rr.fsize = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                        : $urandom_range(13, 300);
                rr.nsize = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 14)
                                                        : $urandom_range(15, 40);
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    rr.bad = 3'b111;
                else if (sel < 12)
                    rr.bad = 3'(1 << $urandom_range(0, 2));
                else
                    rr.bad = 3'b000;
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    rr.nk = NM_PLAIN;
                else if (sel < 75)
                    rr.nk = NM_DOT;
                else if (sel < 90)
                    rr.nk = NM_TRAILER;
                else
                    rr.nk = NM_NEAR;
                if (rr.nk == NM_TRAILER)
                    rr.nsize = ($urandom_range(0, 99) < 80) ? $urandom_range(10, 16)
                                                            : $urandom_range(1, 9);
                n_eff  = rr.bad[FLAG_NAMELEN] ? 32'd0 : rr.nsize;
                rr.cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 110 + n_eff) : 0;
                if (rr.nk == NM_TRAILER)
                    rr.junk = $urandom_range(0, 20);
                need_restart = (rr.nk == NM_TRAILER) || (rr.cut > 0);
                send_entry(rr);
            end
            ents++;
        end

        // Drain and let the block settle.
        arch_ch.valid <= 1'b0;
        @(posedge clk);
        while (entry_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d archive words in %0d entries and %0d noise runs, %0d restarts.",
                 bytes_sent, entries_sent, ents - (entries_sent - dir_rows.size()),
                 restarts_seen);
        $display("Checked %0d records: %0d trailers, %0d dot names, %0d with bad hex digits.",
                 recs_checked, trailers_seen, dots_seen, bad_seen);
        if (errs == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
